/* rtl/prrs_pkg.sv */
// package: types, codes and helpers of the priority round robin scheduler
`timescale 1ns / 1ps

package prrs_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam logic [15:0] QUANTUM_RST = 16'd10;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [0:0] REG_QUANTUM = 1'b0;

    typedef enum logic [2:0] {
        ST_ADDED = 3'd0,
        ST_FULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_SLICE = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_INS,
        S_D_HEAD,
        S_D_SHIFT,
        S_D_TAIL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [63:0] task_name;
        logic [7:0]  priority_req;
        logic [15:0] burst;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] slice_task;
        logic [15:0] slice_length;
        logic        task_finished;
        logic [31:0] time_now;
    } t_out;

    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  prio;
        logic [15:0] burst;
    } t_entry;

    // a goes ahead of b: higher priority, then smaller name
    function automatic logic goes_before(input logic [7:0] pa, input logic [63:0] na,
                                         input logic [7:0] pb, input logic [63:0] nb);
        logic r;
        if (pa != pb) begin
            r = pa > pb;
        end else begin
            r = na < nb;
        end
        return r;
    endfunction

endpackage

/* rtl/prrs_mem.sv */
// task table memory: one write port, one read port, registered read data
`timescale 1ns / 1ps

module prrs_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  prrs_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output prrs_pkg::t_entry o_rdata
);
    import prrs_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/prrs_ctrl.sv */
// sequencer: scans and shifts the ordered task table through the memory
`timescale 1ns / 1ps

module prrs_ctrl #(
    parameter int MAX_TASKS = 16,
    parameter int AW        = 4,
    parameter int CW        = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_quantum,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  prrs_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output prrs_pkg::t_out   o_out,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output prrs_pkg::t_entry o_mem_wdata,
    output logic [AW-1:0]    o_mem_raddr,
    input  prrs_pkg::t_entry i_mem_rdata
);
    import prrs_pkg::*;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    t_state        r_state, n_state;
    t_in           r_item, n_item;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_found, n_found;
    logic          r_dup, n_dup;
    logic          r_fin, n_fin;
    t_entry        r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_time, n_time;
    t_out          r_res, n_res;
    t_out          r_out, n_out;
    logic          r_out_valid, n_out_valid;

    t_entry        e;
    t_entry        rot_head;
    logic          is_last;
    logic          dup_now;
    logic          found_now;
    logic [CW-1:0] pos_now;
    logic          fin_now;
    logic [31:0]   time_fin;
    logic [31:0]   time_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_ptr   <= n_ptr;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_dup   <= n_dup;
        r_fin   <= n_fin;
        r_head  <= n_head;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_comb begin
        e         = i_mem_rdata;
        rot_head  = '{name: r_head.name, prio: r_head.prio,
                      burst: r_head.burst - i_quantum};
        is_last   = (r_ptr == r_count - ONE);
        dup_now   = r_dup | ((e.name == r_item.task_name) && (e.prio == r_item.priority_req));
        found_now = r_found;
        pos_now   = r_pos;
        if (!r_found && goes_before(r_item.priority_req, r_item.task_name, e.prio, e.name)) begin
            found_now = 1'b1;
            pos_now   = r_ptr;
        end
        fin_now  = r_fin | ((r_ptr == ONE) && (e.prio != r_head.prio));
        time_fin = r_time + {16'b0, r_head.burst};
        time_rot = r_time + {16'b0, i_quantum};

        n_state     = r_state;
        n_item      = r_item;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_found     = r_found;
        n_dup       = r_dup;
        n_fin       = r_fin;
        n_head      = r_head;
        n_count     = r_count;
        n_time      = r_time;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;

        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = e;
        o_mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in;
                    if (i_in.operation == OP_ADD) begin
                        n_dup   = 1'b0;
                        n_found = 1'b0;
                        n_ptr   = '0;
                        if (r_count == '0) begin
                            n_pos   = '0;
                            n_state = S_INS;
                        end else begin
                            n_pos   = r_count;
                            n_state = S_SCAN;
                        end
                    end else if (r_count == '0) begin
                        n_res   = '{status: ST_EMPTY, slice_task: '0, slice_length: '0,
                                    task_finished: 1'b0, time_now: r_time};
                        n_state = S_OUT;
                    end else begin
                        n_state = S_D_HEAD;
                    end
                end
            end
            S_SCAN: begin
                n_dup   = dup_now;
                n_found = found_now;
                n_pos   = pos_now;
                if (!is_last) begin
                    n_ptr       = r_ptr + ONE;
                    o_mem_raddr = AW'(r_ptr + ONE);
                end else if (dup_now) begin
                    n_res   = '{status: ST_DUP, slice_task: '0, slice_length: '0,
                                task_finished: 1'b0, time_now: r_time};
                    n_state = S_OUT;
                end else if (r_count == MAX_CNT) begin
                    n_res   = '{status: ST_FULL, slice_task: '0, slice_length: '0,
                                task_finished: 1'b0, time_now: r_time};
                    n_state = S_OUT;
                end else if (pos_now == r_count) begin
                    n_state = S_INS;
                end else begin
                    // move the tail up one slot, last entry first
                    n_ptr       = r_count - ONE;
                    o_mem_raddr = AW'(r_count - ONE);
                    n_state     = S_SHIFT_UP;
                end
            end
            S_SHIFT_UP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_ptr + ONE);
                if (r_ptr == r_pos) begin
                    n_state = S_INS;
                end else begin
                    n_ptr       = r_ptr - ONE;
                    o_mem_raddr = AW'(r_ptr - ONE);
                end
            end
            S_INS: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_pos);
                o_mem_wdata = '{name: r_item.task_name, prio: r_item.priority_req,
                                burst: r_item.burst};
                n_count     = r_count + ONE;
                n_res       = '{status: ST_ADDED, slice_task: '0, slice_length: '0,
                                task_finished: 1'b0, time_now: r_time};
                n_state     = S_OUT;
            end
            S_D_HEAD: begin
                n_head = e;
                if (r_count == ONE) begin
                    n_count = '0;
                    n_time  = r_time + {16'b0, e.burst};
                    n_res   = '{status: ST_SLICE, slice_task: e.name, slice_length: e.burst,
                                task_finished: 1'b1, time_now: r_time + {16'b0, e.burst}};
                    n_state = S_OUT;
                end else begin
                    n_fin       = (e.burst <= i_quantum);
                    n_ptr       = ONE;
                    o_mem_raddr = AW'(ONE);
                    n_state     = S_D_SHIFT;
                end
            end
            S_D_SHIFT: begin
                // writes land one slot below the entry read, never on the next read
                n_fin       = fin_now;
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_ptr - ONE);
                if (fin_now || (e.prio == r_head.prio)) begin
                    if (!is_last) begin
                        n_ptr       = r_ptr + ONE;
                        o_mem_raddr = AW'(r_ptr + ONE);
                    end else if (fin_now) begin
                        n_count = r_count - ONE;
                        n_time  = time_fin;
                        n_res   = '{status: ST_SLICE, slice_task: r_head.name,
                                    slice_length: r_head.burst, task_finished: 1'b1,
                                    time_now: time_fin};
                        n_state = S_OUT;
                    end else begin
                        n_state = S_D_TAIL;
                    end
                end else begin
                    // end of the priority group: head goes in the freed slot
                    o_mem_wdata = rot_head;
                    n_time      = time_rot;
                    n_res       = '{status: ST_SLICE, slice_task: r_head.name,
                                    slice_length: i_quantum, task_finished: 1'b0,
                                    time_now: time_rot};
                    n_state     = S_OUT;
                end
            end
            S_D_TAIL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_ptr);
                o_mem_wdata = rot_head;
                n_time      = time_rot;
                n_res       = '{status: ST_SLICE, slice_task: r_head.name,
                                slice_length: i_quantum, task_finished: 1'b0,
                                time_now: time_rot};
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/priority_round_robin_scheduler.sv */
// top level: configuration register, task table memory and sequencer
//
// channel | direction | handshake           | beat
// in      | input     | i_in_valid/o_in_ready   | t_in: operation, name, priority, burst
// out     | output    | o_out_valid/i_out_ready | t_out: status, slice, length, finished, time
// config  | input     | psel/penable/pready     | quantum at byte address 0
//
// an add scans the stored tasks, then shifts the tail up (scan, then shift), and a
// dispatch reads up to every stored task; the single read port of the table paces both.
// one item is in work at a time; the next is taken while the last result waits.
// reset clears the task count and elapsed time and sets the quantum to 10;
// table contents are not cleared.
// a stalled output holds the result register and the sequencer waits before loading.
`timescale 1ns / 1ps

module priority_round_robin_scheduler
    import prrs_pkg::*;
#(
    parameter int MAX_TASKS = prrs_pkg::MAX_TASKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  prrs_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output prrs_pkg::t_out o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [15:0]   r_quantum;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUANTUM)) begin
            r_quantum <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUANTUM) ? {16'b0, r_quantum} : 32'b0;

    prrs_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    prrs_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_quantum   (r_quantum),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

/* rtl/prrs_checker.sv */
// port checker for the scheduler, bound to the top level
`timescale 1ns / 1ps

module prrs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input prrs_pkg::t_out o_out
);
    import prrs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result beat dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status <= ST_EMPTY))
        else $error("status code out of range");

    a_no_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_SLICE)) |->
            ((o_out.slice_length == '0) && !o_out.task_finished && (o_out.slice_task == '0)))
        else $error("slice fields set on a non-dispatch result");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
